>>> rtl/act2p_pkg.sv
package act2p_pkg;

   localparam int COUNT_BITS      = 10;
   localparam int FRACTION_BITS   = 8;
   localparam int ECHO_TIMEOUT_US = 32000;

   localparam int SEC_BITS   = 8;
   localparam int ECHO_BITS  = 15;
   localparam int CPS_BITS   = 18;
   localparam int DIV_BITS   = COUNT_BITS + FRACTION_BITS;
   localparam int DCNT_BITS  = $clog2(DIV_BITS);

   localparam int REQ_BITS   = 24;
   localparam int RSP_BITS   = 48;

   localparam logic [1:0] CSR_MAX_GREEN  = 2'd0;
   localparam logic [1:0] CSR_GAP_LIMIT  = 2'd1;
   localparam logic [1:0] CSR_ECHO_LIMIT = 2'd2;

   localparam logic [SEC_BITS-1:0]  MAX_GREEN_RESET  = 8'd30;
   localparam logic [SEC_BITS-1:0]  GAP_LIMIT_RESET  = 8'd10;
   localparam logic [ECHO_BITS-1:0] ECHO_LIMIT_RESET = 15'd17;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

>>> rtl/actuated_two_phase_signal.sv
// Two-phase actuated signal controller, north and west approaches.
// req channel: one sensor poll per item for the direction that is green.
// rsp channel: exactly one result item per poll, in order.
// csr port: csr_we with csr_index 0 max green, 1 gap limit, 2 echo limit;
//   other indexes are ignored. Write only while no poll is in flight.
// A poll's result goes to the result registers on acceptance and then, in
//   the load state and once the output register is free, to the output
//   register. A poll that ends a phase first runs the serial divider for the
//   rate figure, one quotient bit per cycle (18 bits); a zero-second phase
//   skips the divider. A new poll is taken only in the idle state, after the
//   last result has gone to the output register.
// The result sits in an output register, so the next poll is taken while a
//   result waits; a stalled receiver blocks the next result and new polls.
// Reset: north green, all timers and the car count clear, registers return
//   to 30 s max green, 10 s gap limit, 17 us echo limit. No clearing pass.
module actuated_two_phase_signal (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // echo_seen, echo_width_us[15], second_tick, zero pad
   input  logic [act2p_pkg::REQ_BITS-1:0]   req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // north_green, interval_done, interval_direction, interval_cars[10],
   // interval_seconds[8], ended_by_gap, cars_per_second_q8[18], sensor_fault,
   // zero pad
   output logic [act2p_pkg::RSP_BITS-1:0]   rsp_tdata,
   input  logic                             csr_we,
   input  logic [1:0]                       csr_index,
   input  logic [act2p_pkg::ECHO_BITS-1:0]  csr_wdata
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_DIVIDE = 2'd1;
   localparam logic [1:0] ST_LOAD   = 2'd2;

   localparam int SB = act2p_pkg::SEC_BITS;
   localparam int CB = act2p_pkg::COUNT_BITS;

   logic [1:0]                         state_ff, state_in;

   logic [SB-1:0]                      max_green_ff, max_green_in;
   logic [SB-1:0]                      gap_limit_ff, gap_limit_in;
   logic [act2p_pkg::ECHO_BITS-1:0]    echo_limit_ff, echo_limit_in;

   logic                               phase_west_ff, phase_west_in;
   logic [SB-1:0]                      phase_sec_ff, phase_sec_in;
   logic [SB-1:0]                      gap_sec_ff, gap_sec_in;
   logic [CB-1:0]                      car_count_ff, car_count_in;

   logic                               res_north_ff, res_north_in;
   logic                               res_done_ff, res_done_in;
   logic                               res_dir_ff, res_dir_in;
   logic [CB-1:0]                      res_cars_ff, res_cars_in;
   logic [SB-1:0]                      res_secs_ff, res_secs_in;
   logic                               res_gap_ff, res_gap_in;
   logic [act2p_pkg::CPS_BITS-1:0]     res_cps_ff, res_cps_in;
   logic                               res_fault_ff, res_fault_in;

   logic                               rsp_valid_ff, rsp_valid_in;
   logic [act2p_pkg::RSP_BITS-1:0]     rsp_data_ff, rsp_data_in;

   logic                               accept;
   logic                               echo_seen;
   logic [act2p_pkg::ECHO_BITS-1:0]    echo_width;
   logic                               tick;
   logic                               fault;
   logic                               car;
   logic [SB:0]                        next_phase;
   logic [SB:0]                        next_gap;
   logic                               end_max;
   logic                               end_gap;
   logic                               phase_end;
   logic [SB-1:0]                      secs;
   logic [CB-1:0]                      count_next;
   logic                               out_free;
   logic                               load;

   logic                               div_start;
   logic [act2p_pkg::DIV_BITS-1:0]     div_dividend;
   act2p_pkg::div_status_type          div_status;
   logic [act2p_pkg::DIV_BITS-1:0]     div_quotient;

   assign req_tready = state_ff == ST_IDLE;
   assign accept     = req_tvalid && req_tready;

   assign echo_seen  = req_tdata[0];
   assign echo_width = req_tdata[act2p_pkg::ECHO_BITS:1];
   assign tick       = req_tdata[act2p_pkg::ECHO_BITS+1];

   assign fault = !echo_seen
               || ({1'b0, echo_width} >= 16'(act2p_pkg::ECHO_TIMEOUT_US));
   assign car   = !fault && (echo_width <= echo_limit_ff);

   assign next_phase = {1'b0, phase_sec_ff} + {{SB{1'b0}}, tick};
   assign next_gap   = car ? '0 : ({1'b0, gap_sec_ff} + {{SB{1'b0}}, tick});
   assign end_max    = next_phase > {1'b0, max_green_ff};
   assign end_gap    = !end_max && (next_gap > {1'b0, gap_limit_ff});
   assign phase_end  = end_max || end_gap;
   assign secs       = end_max ? max_green_ff : next_phase[SB-1:0];
   assign count_next = (car && (car_count_ff != {CB{1'b1}})) ? car_count_ff + 1'b1
                                                               : car_count_ff;

   assign div_start    = accept && phase_end && (secs != '0);
   assign div_dividend = {count_next, {act2p_pkg::FRACTION_BITS{1'b0}}};

   act2p_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (secs),
      .status   (div_status),
      .quotient (div_quotient)
   );

   always_comb begin
      max_green_in  = max_green_ff;
      gap_limit_in  = gap_limit_ff;
      echo_limit_in = echo_limit_ff;
      if (csr_we) begin
         unique case (csr_index)
            act2p_pkg::CSR_MAX_GREEN:  max_green_in  = csr_wdata[SB-1:0];
            act2p_pkg::CSR_GAP_LIMIT:  gap_limit_in  = csr_wdata[SB-1:0];
            act2p_pkg::CSR_ECHO_LIMIT: echo_limit_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in      = state_ff;
      phase_west_in = phase_west_ff;
      phase_sec_in  = phase_sec_ff;
      gap_sec_in    = gap_sec_ff;
      car_count_in  = car_count_ff;
      res_north_in  = res_north_ff;
      res_done_in   = res_done_ff;
      res_dir_in    = res_dir_ff;
      res_cars_in   = res_cars_ff;
      res_secs_in   = res_secs_ff;
      res_gap_in    = res_gap_ff;
      res_cps_in    = res_cps_ff;
      res_fault_in  = res_fault_ff;
      load          = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               res_done_in  = phase_end;
               res_fault_in = fault;
               res_cps_in   = '0;
               if (phase_end) begin
                  res_dir_in    = phase_west_ff;
                  res_cars_in   = count_next;
                  res_secs_in   = secs;
                  res_gap_in    = end_gap;
                  phase_west_in = !phase_west_ff;
                  res_north_in  = phase_west_ff;
                  phase_sec_in  = '0;
                  gap_sec_in    = '0;
                  car_count_in  = '0;
               end else begin
                  res_dir_in   = 1'b0;
                  res_cars_in  = '0;
                  res_secs_in  = '0;
                  res_gap_in   = 1'b0;
                  res_north_in = !phase_west_ff;
                  phase_sec_in = next_phase[SB-1:0];
                  gap_sec_in   = next_gap[SB-1:0];
                  car_count_in = count_next;
               end
               state_in = div_start ? ST_DIVIDE : ST_LOAD;
            end
         end
         ST_DIVIDE: begin
            if (div_status.done) begin
               res_cps_in = div_quotient;
               state_in   = ST_LOAD;
            end
         end
         ST_LOAD: begin
            if (out_free) begin
               load     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign out_free     = !rsp_valid_ff || rsp_tready;
   assign rsp_valid_in = load ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   assign rsp_data_in  = load ? {7'd0, res_fault_ff, res_cps_ff, res_gap_ff, res_secs_ff,
                                 res_cars_ff, res_dir_ff, res_done_ff, res_north_ff}
                              : rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         max_green_ff  <= act2p_pkg::MAX_GREEN_RESET;
         gap_limit_ff  <= act2p_pkg::GAP_LIMIT_RESET;
         echo_limit_ff <= act2p_pkg::ECHO_LIMIT_RESET;
         phase_west_ff <= 1'b0;
         phase_sec_ff  <= '0;
         gap_sec_ff    <= '0;
         car_count_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         max_green_ff  <= max_green_in;
         gap_limit_ff  <= gap_limit_in;
         echo_limit_ff <= echo_limit_in;
         phase_west_ff <= phase_west_in;
         phase_sec_ff  <= phase_sec_in;
         gap_sec_ff    <= gap_sec_in;
         car_count_ff  <= car_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      res_north_ff <= res_north_in;
      res_done_ff  <= res_done_in;
      res_dir_ff   <= res_dir_in;
      res_cars_ff  <= res_cars_in;
      res_secs_ff  <= res_secs_in;
      res_gap_ff   <= res_gap_in;
      res_cps_ff   <= res_cps_in;
      res_fault_ff <= res_fault_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef ASSERT_OFF
   a_div_only_in_divide: assert property (@(posedge clock) disable iff (reset)
      div_status.busy |-> state_ff == ST_DIVIDE)
      else $error("divider busy outside divide state");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOAD && rsp_valid_ff && !rsp_tready) |=> state_ff == ST_LOAD)
      else $error("result loaded over a stalled item");

   a_quiet_fields: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOAD && !res_done_ff) |-> (res_cars_ff == '0 && res_cps_ff == '0
                                                  && res_secs_ff == '0))
      else $error("summary fields set without a phase end");

   a_phase_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && phase_end) |=> (car_count_ff == '0 && phase_sec_ff == '0
                                 && gap_sec_ff == '0))
      else $error("counters not cleared at phase end");
`endif

endmodule

>>> rtl/act2p_div.sv
module act2p_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [act2p_pkg::DIV_BITS-1:0]    dividend,
   input  logic [act2p_pkg::SEC_BITS-1:0]    divisor,
   output act2p_pkg::div_status_type         status,
   output logic [act2p_pkg::DIV_BITS-1:0]    quotient
);

   logic                               busy_ff, busy_in;
   logic                               done_ff, done_in;
   logic [act2p_pkg::DCNT_BITS-1:0]    count_ff, count_in;
   logic [act2p_pkg::SEC_BITS-1:0]     rem_ff, rem_in;
   logic [act2p_pkg::SEC_BITS-1:0]     divisor_ff, divisor_in;
   logic [act2p_pkg::DIV_BITS-1:0]     quot_ff, quot_in;
   logic [act2p_pkg::SEC_BITS:0]       trial;
   logic [act2p_pkg::SEC_BITS:0]       diff;
   logic                               fits;
   logic                               last;

   assign trial = {rem_ff, quot_ff[act2p_pkg::DIV_BITS-1]};
   assign diff  = trial - {1'b0, divisor_ff};
   assign fits  = trial >= {1'b0, divisor_ff};
   assign last  = count_ff == act2p_pkg::DCNT_BITS'(act2p_pkg::DIV_BITS - 1);

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      count_in   = count_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      quot_in    = quot_ff;
      if (start) begin
         busy_in    = 1'b1;
         count_in   = '0;
         rem_in     = '0;
         divisor_in = divisor;
         quot_in    = dividend;
      end else if (busy_ff) begin
         rem_in   = fits ? diff[act2p_pkg::SEC_BITS-1:0] : trial[act2p_pkg::SEC_BITS-1:0];
         quot_in  = {quot_ff[act2p_pkg::DIV_BITS-2:0], fits};
         count_in = count_ff + 1'b1;
         if (last) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
      quot_ff    <= quot_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = quot_ff;

endmodule

>>> tb/phase_report_checker.sv
module phase_report_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   // echo_seen, echo_width_us[15], second_tick, zero pad
   input  logic [act2p_pkg::REQ_BITS-1:0]  req_tdata,
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // north_green, interval_done, interval_direction, interval_cars[10],
   // interval_seconds[8], ended_by_gap, cars_per_second_q8[18], sensor_fault,
   // zero pad
   input  logic [act2p_pkg::RSP_BITS-1:0]  rsp_tdata,
   input  logic                            csr_we,
   input  logic [1:0]                      csr_index,
   input  logic [act2p_pkg::ECHO_BITS-1:0] csr_wdata,
   output int                              fail_count,
   output int                              outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SB      = act2p_pkg::SEC_BITS;
   localparam int CB      = act2p_pkg::COUNT_BITS;
   localparam int EB      = act2p_pkg::ECHO_BITS;
   localparam int PB      = act2p_pkg::CPS_BITS;
   localparam int CAR_MAX = (1 << CB) - 1;
   localparam int CPS_MAX = (1 << PB) - 1;

   typedef struct packed {
      logic          north_green;
      logic          interval_done;
      logic          interval_direction;
      logic [CB-1:0] interval_cars;
      logic [SB-1:0] interval_seconds;
      logic          ended_by_gap;
      logic [PB-1:0] cars_per_second_q8;
      logic          sensor_fault;
   } phase_report_type;

   logic [SB-1:0] max_green;
   logic [SB-1:0] gap_limit;
   logic [EB-1:0] echo_limit;
   logic          west_green;
   int            phase_seconds;
   int            gap_seconds;
   int            car_count;

   phase_report_type expected_reports[$];
   int               mismatches = 0;
   int               pending_reports = 0;

   assign fail_count  = mismatches;
   assign outstanding = pending_reports;

   function automatic phase_report_type predict_poll(input logic seen,
                                                     input logic [EB-1:0] width,
                                                     input logic tick);
      phase_report_type r;
      logic             fault;
      logic             car;
      int               next_phase;
      int               next_gap;
      int               rate;
      r          = '0;
      fault      = !seen || (width >= act2p_pkg::ECHO_TIMEOUT_US);
      car        = !fault && (width <= echo_limit);
      next_phase = phase_seconds + int'(tick);
      next_gap   = gap_seconds + int'(tick);
      // the tick lands first, then a car restarts the gap timer
      if (car) begin
         if (car_count < CAR_MAX)
            car_count++;
         next_gap = 0;
      end
      if (next_phase > int'(max_green)) begin
         r.interval_done    = 1'b1;
         r.interval_seconds = max_green;
      end else if (next_gap > int'(gap_limit)) begin
         r.interval_done    = 1'b1;
         r.ended_by_gap     = 1'b1;
         r.interval_seconds = SB'(next_phase);
      end
      if (r.interval_done) begin
         r.interval_direction = west_green;
         r.interval_cars      = CB'(car_count);
         rate = (r.interval_seconds == 0) ? 0 :
                (car_count << act2p_pkg::FRACTION_BITS) / int'(r.interval_seconds);
         r.cars_per_second_q8 = PB'((rate > CPS_MAX) ? CPS_MAX : rate);
         west_green    = !west_green;
         phase_seconds = 0;
         gap_seconds   = 0;
         car_count     = 0;
      end else begin
         phase_seconds = next_phase & 255;
         gap_seconds   = next_gap & 255;
      end
      r.north_green  = !west_green;
      r.sensor_fault = fault;
      return r;
   endfunction

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      phase_report_type want;
      phase_report_type got;
      if (reset) begin
         max_green     = act2p_pkg::MAX_GREEN_RESET;
         gap_limit     = act2p_pkg::GAP_LIMIT_RESET;
         echo_limit    = act2p_pkg::ECHO_LIMIT_RESET;
         west_green    = 1'b0;
         phase_seconds = 0;
         gap_seconds   = 0;
         car_count     = 0;
         expected_reports.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               act2p_pkg::CSR_MAX_GREEN:  max_green  = csr_wdata[SB-1:0];
               act2p_pkg::CSR_GAP_LIMIT:  gap_limit  = csr_wdata[SB-1:0];
               act2p_pkg::CSR_ECHO_LIMIT: echo_limit = csr_wdata;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            expected_reports.push_back(predict_poll(req_tdata[0], req_tdata[15:1],
                                                    req_tdata[16]));
         if (rsp_tvalid && rsp_tready) begin
            got.north_green        = rsp_tdata[0];
            got.interval_done      = rsp_tdata[1];
            got.interval_direction = rsp_tdata[2];
            got.interval_cars      = rsp_tdata[12:3];
            got.interval_seconds   = rsp_tdata[20:13];
            got.ended_by_gap       = rsp_tdata[21];
            got.cars_per_second_q8 = rsp_tdata[39:22];
            got.sensor_fault       = rsp_tdata[40];
            if (expected_reports.size() == 0) begin
               $error("result item with no poll outstanding");
               mismatches++;
            end else begin
               want = expected_reports.pop_front();
               check_field("north_green", want.north_green, got.north_green);
               check_field("interval_done", want.interval_done, got.interval_done);
               check_field("interval_direction", want.interval_direction,
                           got.interval_direction);
               check_field("interval_cars", want.interval_cars, got.interval_cars);
               check_field("interval_seconds", want.interval_seconds,
                           got.interval_seconds);
               check_field("ended_by_gap", want.ended_by_gap, got.ended_by_gap);
               check_field("cars_per_second_q8", want.cars_per_second_q8,
                           got.cars_per_second_q8);
               check_field("sensor_fault", want.sensor_fault, got.sensor_fault);
            end
         end
      end
      pending_reports <= expected_reports.size();
   end

endmodule

>>> tb/tb_actuated_two_phase_signal.sv
module tb_actuated_two_phase_signal;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int         EB          = act2p_pkg::ECHO_BITS;
   localparam int         TIMEOUT     = act2p_pkg::ECHO_TIMEOUT_US;
   localparam logic [1:0] CSR_UNUSED  = 2'd3;
   localparam int         CYCLE_LIMIT = 1000000;
   localparam int         SETTLE      = 30;

   logic                              clock      = 1'b0;
   logic                              reset      = 1'b1;
   logic                              req_tvalid = 1'b0;
   logic                              req_tready;
   logic [act2p_pkg::REQ_BITS-1:0]    req_tdata  = '0;
   logic                              rsp_tvalid;
   logic                              rsp_tready = 1'b0;
   logic [act2p_pkg::RSP_BITS-1:0]    rsp_tdata;
   logic                              csr_we     = 1'b0;
   logic [1:0]                        csr_index  = act2p_pkg::CSR_MAX_GREEN;
   logic [EB-1:0]                     csr_wdata  = '0;

   int fail_count;
   int outstanding;
   int send_pct    = 0;
   int recv_pct    = 0;
   int cycle_count = 0;

   actuated_two_phase_signal DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   phase_report_checker checker_i (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= recv_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   task automatic set_idling(input int sender, input int receiver);
      send_pct <= sender;
      recv_pct <= receiver;
   endtask

   task automatic send_poll(input logic seen, input logic [EB-1:0] width,
                            input logic tick);
      if ($urandom_range(0, 99) < send_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < send_pct);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= act2p_pkg::REQ_BITS'({tick, width, seen});
      do @(posedge clock); while (!req_tready);
   endtask

   // hold polls back until every result item is in
   task automatic drain;
      req_tvalid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic program_regs(input logic [EB-1:0] max_green,
                               input logic [EB-1:0] gap_limit,
                               input logic [EB-1:0] echo_limit);
      drain();
      repeat (SETTLE) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= act2p_pkg::CSR_MAX_GREEN;
      csr_wdata <= max_green;
      @(posedge clock);
      csr_index <= act2p_pkg::CSR_GAP_LIMIT;
      csr_wdata <= gap_limit;
      @(posedge clock);
      csr_index <= act2p_pkg::CSR_ECHO_LIMIT;
      csr_wdata <= echo_limit;
      @(posedge clock);
      csr_index <= CSR_UNUSED;
      csr_wdata <= EB'($urandom);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic random_poll(input int echo_lim, input int tick_pct);
      int            pick;
      logic          seen;
      logic [EB-1:0] width;
      pick = $urandom_range(0, 99);
      seen = 1'b1;
      if (pick < 45)
         width = EB'($urandom_range(0, echo_lim));
      else if (pick < 50)
         width = EB'(echo_lim);
      else if (pick < 55)
         width = EB'((echo_lim < TIMEOUT) ? echo_lim + 1 : echo_lim);
      else if (pick < 60) begin
         seen  = 1'b0;
         width = EB'($urandom_range(0, TIMEOUT));
      end else if (pick < 65)
         width = EB'(TIMEOUT);
      else
         width = EB'($urandom_range(0, TIMEOUT));
      send_poll(seen, width, $urandom_range(0, 99) < tick_pct);
   endtask

   task automatic run_phase(input int max_green, input int gap_limit, input int echo_lim,
                            input int items, input int tick_pct);
      program_regs(EB'(max_green), EB'(gap_limit), EB'(echo_lim));
      for (int i = 0; i < items; i++) begin
         if ($urandom_range(0, 39) == 0)
            drain();
         random_poll(echo_lim, tick_pct);
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      set_idling(34, 49);
      @(posedge clock);

      // reset limits: 17 us is a car, 18 us is not
      send_poll(1'b1, 15'd0, 1'b0);
      send_poll(1'b1, 15'd17, 1'b0);
      send_poll(1'b1, 15'd18, 1'b0);
      send_poll(1'b0, 15'd5, 1'b0);
      send_poll(1'b1, 15'd32000, 1'b0);
      send_poll(1'b1, 15'd31999, 1'b0);

      // high bits of the 8-bit registers drop: max green 3, gap limit 1
      program_regs(15'h7F03, 15'h7F01, 15'd100);
      // gap-out on north
      send_poll(1'b1, 15'd100, 1'b1);
      send_poll(1'b1, 15'd5000, 1'b1);
      send_poll(1'b1, 15'd5000, 1'b1);
      // max green on west, car and tick together each poll
      repeat (4) send_poll(1'b1, 15'd50, 1'b1);
      // both limits on one poll, fault keeps the gap timer running
      send_poll(1'b1, 15'd50, 1'b1);
      send_poll(1'b1, 15'd50, 1'b1);
      send_poll(1'b1, 15'd5000, 1'b1);
      send_poll(1'b0, 15'd0, 1'b1);

      run_phase(5, 2, 1000, 150, 50);
      // zero-second phases
      run_phase(0, 3, 17, 60, 30);

      set_idling(49, 34);
      run_phase(255, 255, 32000, 100, 60);
      run_phase(8, 1, 0, 150, 50);

      set_idling(0, 0);
      run_phase(30, 10, 17, 130, 60);

      // count a run of cars, then end on max green after one second
      program_regs(15'd1, 15'd255, 15'd20000);
      repeat (12) send_poll(1'b1, EB'($urandom_range(0, 20000)), 1'b0);
      repeat (3) send_poll(1'b1, 15'd30000, 1'b1);

      drain();
      repeat (SETTLE) @(posedge clock);
      if (fail_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

>>> sim.f
rtl/act2p_pkg.sv
rtl/act2p_div.sv
rtl/actuated_two_phase_signal.sv
tb/phase_report_checker.sv
tb/tb_actuated_two_phase_signal.sv
